@@ hdl/clt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants for the command line tokenizer
// Result encoding, the per-request result bundle and queue sizing.
// ----------------------------------------------------------------------------
package clt_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  // configuration register indexes
  localparam logic REG_ESCAPE = 1'b0;
  localparam logic REG_WRAP   = 1'b1;

  // results one request can produce, and the bundle index width
  localparam int MaxRes = 4;
  localparam int ResW   = $clog2(MaxRes);

  // front-to-back queue
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } res_t;

  // all results of one request; last is the index of the final one
  typedef struct packed {
    logic [ResW-1:0]        last;
    res_t [MaxRes-1:0]      ent;
  } bundle_t;

endpackage
`default_nettype wire

@@ hdl/clt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_front: tokenizer parse and escape front end
// Classifies each request and builds the bundle of results it causes.
// ----------------------------------------------------------------------------
module clt_front
  import clt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       line_end,
  output logic            push,
  output bundle_t         push_data
);

  typedef enum logic [3:0] {
    M_IDLE, M_DQ, M_SQ, M_WORD, M_DASH, M_SHORT, M_DASH2, M_LONG,
    M_EQ, M_EQ_DQ, M_EQ_SQ, M_EQ_WORD
  } mode_t;

  typedef enum logic [1:0] {E_OUT, E_DQ, E_SQ} emode_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a) || c == CH_DASH || c == 8'h5f;
  endfunction

  function automatic logic is_meta(input logic [7:0] c);
    return c == 8'h3c || c == 8'h3e || c == 8'h28 || c == 8'h29 ||
           c == 8'h3b || c == 8'h26 || c == 8'h7c;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h72:   r = 8'd13;  // r
      8'h6e:   r = 8'd10;  // n
      8'h74:   r = 8'd9;   // t
      8'h61:   r = 8'd7;   // a
      default: r = c;
    endcase
    return r;
  endfunction

  logic   escape_enable, wrap_enable;
  mode_t  mode, mode_next;
  logic   after_bsl, after_bsl_next;
  emode_t esc_mode, esc_mode_next;
  logic   esc_pend, esc_pend_next;
  logic   tok_open, tok_open_next;

  logic       do_push, do_fin;
  logic [7:0] pch;
  logic [2:0] n;
  bundle_t    bun;

  always_comb begin
    mode_next      = mode;
    after_bsl_next = after_bsl;
    esc_mode_next  = esc_mode;
    esc_pend_next  = esc_pend;
    tok_open_next  = tok_open;
    do_push        = 1'b0;
    do_fin         = 1'b0;
    pch            = in_byte;
    n              = 3'd0;
    bun            = '0;

    // --- parse: decide push / finish and the next mode
    if (line_end) begin
      after_bsl_next = 1'b0;
      do_fin         = 1'b1;
      mode_next      = M_IDLE;
    end else if (after_bsl) begin
      after_bsl_next = 1'b0;
      do_push        = 1'b1;
      pch            = unescape(in_byte);
    end else begin
      case (mode)
        M_DQ, M_SQ: begin
          if (in_byte == CH_BSL) after_bsl_next = 1'b1;
          else if (in_byte == ((mode == M_DQ) ? CH_DQ : CH_SQ)) begin
            mode_next = M_IDLE;
            do_fin    = 1'b1;
          end else do_push = 1'b1;
        end
        M_WORD: begin
          if (is_space(in_byte)) begin
            mode_next = M_IDLE;
            do_fin    = 1'b1;
          end else if (in_byte != CH_DQ && in_byte != CH_SQ) do_push = 1'b1;
        end
        M_DASH: begin
          if (in_byte == CH_DASH) begin
            mode_next = M_DASH2;
            do_push   = 1'b1;
          end else if (is_name(in_byte)) begin
            mode_next = M_SHORT;
            do_push   = 1'b1;
          end else begin
            mode_next = M_IDLE;
            do_fin    = 1'b1;
          end
        end
        M_DASH2: begin
          if (is_name(in_byte)) begin
            mode_next = M_LONG;
            do_push   = 1'b1;
          end else begin
            mode_next = M_IDLE;
            do_fin    = 1'b1;
          end
        end
        M_SHORT, M_LONG: begin
          if (is_name(in_byte)) do_push = 1'b1;
          else begin
            mode_next = (in_byte == CH_EQ) ? M_EQ : M_IDLE;
            do_fin    = 1'b1;
          end
        end
        M_EQ: begin
          if (is_space(in_byte)) begin
            mode_next = M_IDLE;
            do_fin    = 1'b1;
          end else if (in_byte == CH_DQ) mode_next = M_EQ_DQ;
          else if (in_byte == CH_SQ) mode_next = M_EQ_SQ;
          else begin
            mode_next = M_EQ_WORD;
            do_push   = 1'b1;
          end
        end
        M_EQ_DQ, M_EQ_SQ: begin
          if (in_byte == ((mode == M_EQ_DQ) ? CH_DQ : CH_SQ)) begin
            mode_next = M_IDLE;
            do_fin    = 1'b1;
          end else do_push = 1'b1;
        end
        M_EQ_WORD: begin
          if (is_space(in_byte)) begin
            mode_next = M_IDLE;
            do_fin    = 1'b1;
          end else do_push = 1'b1;
        end
        default: begin
          // idle between tokens
          mode_next = M_IDLE;
          if (is_space(in_byte)) begin
            mode_next = M_IDLE;
          end else if (in_byte == CH_DASH) begin
            mode_next = M_DASH;
            do_push   = 1'b1;
          end else if (in_byte == CH_BSL) after_bsl_next = 1'b1;
          else if (in_byte == CH_DQ) mode_next = M_DQ;
          else if (in_byte == CH_SQ) mode_next = M_SQ;
          else if (in_byte == CH_EQ) mode_next = M_EQ;
          else begin
            mode_next = M_WORD;
            do_push   = 1'b1;
          end
        end
      endcase
    end

    // --- close the token; a pending escape backslash is dropped
    if (do_fin) begin
      if (tok_open) begin
        if (wrap_enable) begin
          bun.ent[n[ResW-1:0]] = '{data: CH_SQ, kind: KIND_BYTE};
          n = n + 3'd1;
        end
        bun.ent[n[ResW-1:0]] = '{data: 8'h00, kind: KIND_TOKEN_END};
        n = n + 3'd1;
      end
      tok_open_next = 1'b0;
      esc_mode_next = E_OUT;
      esc_pend_next = 1'b0;
    end

    // --- token byte, through the optional escape pass
    if (do_push) begin
      if (!tok_open) begin
        tok_open_next = 1'b1;
        esc_mode_next = E_OUT;
        esc_pend_next = 1'b0;
        if (wrap_enable) begin
          bun.ent[n[ResW-1:0]] = '{data: CH_SQ, kind: KIND_BYTE};
          n = n + 3'd1;
        end
      end
      if (!escape_enable) begin
        bun.ent[n[ResW-1:0]] = '{data: pch, kind: KIND_BYTE};
        n = n + 3'd1;
      end else if (esc_pend_next) begin
        esc_pend_next = 1'b0;
        bun.ent[n[ResW-1:0]] = '{data: CH_BSL, kind: KIND_BYTE};
        n = n + 3'd1;
        bun.ent[n[ResW-1:0]] = '{data: pch, kind: KIND_BYTE};
        n = n + 3'd1;
      end else if (pch == CH_BSL) begin
        esc_pend_next = 1'b1;
      end else begin
        case (esc_mode_next)
          E_DQ: begin
            if (pch == CH_DQ) esc_mode_next = E_OUT;
          end
          E_SQ: begin
            if (pch == CH_SQ) begin
              esc_mode_next = E_OUT;
              if (wrap_enable) begin
                bun.ent[n[ResW-1:0]] = '{data: CH_BSL, kind: KIND_BYTE};
                n = n + 3'd1;
              end
            end
          end
          default: begin
            esc_mode_next = E_OUT;
            if (is_meta(pch)) begin
              bun.ent[n[ResW-1:0]] = '{data: CH_BSL, kind: KIND_BYTE};
              n = n + 3'd1;
            end else if (pch == CH_DQ) begin
              esc_mode_next = E_DQ;
            end else if (pch == CH_SQ) begin
              esc_mode_next = E_SQ;
              bun.ent[n[ResW-1:0]] = '{data: CH_BSL, kind: KIND_BYTE};
              n = n + 3'd1;
            end
          end
        endcase
        bun.ent[n[ResW-1:0]] = '{data: pch, kind: KIND_BYTE};
        n = n + 3'd1;
      end
    end

    if (line_end) begin
      bun.ent[n[ResW-1:0]] = '{data: 8'h00, kind: KIND_LINE_END};
      n = n + 3'd1;
    end

    bun.last = ResW'(n - 3'd1);
  end

  assign push      = accept && (n != 3'd0);
  assign push_data = bun;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b1;
      wrap_enable   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ESCAPE) escape_enable <= cfg_data;
      else                         wrap_enable   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      after_bsl <= 1'b0;
      esc_mode  <= E_OUT;
      esc_pend  <= 1'b0;
      tok_open  <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      after_bsl <= after_bsl_next;
      esc_mode  <= esc_mode_next;
      esc_pend  <= esc_pend_next;
      tok_open  <= tok_open_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/clt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_queue: result bundle queue
// Small register FIFO between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module clt_queue
  import clt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  input  wire logic    pop,
  output bundle_t      pop_data,
  output logic         full,
  output logic         empty
);

  bundle_t         mem [QDepth];
  logic [QAw-1:0]  wr_ptr, rd_ptr;
  logic [QAw:0]    count;

  assign full     = (count == (QAw+1)'(QDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/clt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_back: output sequencer
// Steps through each queued bundle, one result per accepted output cycle.
// ----------------------------------------------------------------------------
module clt_back
  import clt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire bundle_t    q_data,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            last_of_run
);

  bundle_t         cur;
  logic            cur_valid;
  logic [ResW-1:0] idx;
  logic            out_acc, at_last;

  assign out_acc = cur_valid && !out_stall;
  assign at_last = (idx == cur.last);
  assign q_pop   = !q_empty && (!cur_valid || (out_acc && at_last));

  assign out_valid   = cur_valid;
  assign out_byte    = cur.ent[idx].data;
  assign out_kind    = cur.ent[idx].kind;
  assign last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (out_acc) begin
      if (at_last) cur_valid <= 1'b0;
      else         idx       <= idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hdl/command_line_tokenizer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_tokenizer_top: shell style command line tokenizer
// Splits a byte stream into tokens with quoting, escapes and option forms.
// ----------------------------------------------------------------------------
// Path: the results of an accepted request are written into the queue as one
//   bundle, then loaded into the output sequencer's bundle register and presented.
// Throughput: one request per cycle into the front end while the queue is not
//   full; results leave at one per cycle while out_stall is low.
//   The output sequencer sets the sustained rate; the 4-deep queue holds the
//   result bundles of up to four requests, each of up to four results.
// Reset (rst, synchronous): parser idle between tokens, queue empty,
//   escape_enable = 1, wrap_enable = 0.
// ----------------------------------------------------------------------------
module command_line_tokenizer_top
  import clt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write port
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  // request channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       line_end,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            last_of_run
);

  logic    accept;
  logic    push, pop, q_full, q_empty;
  bundle_t push_data, pop_data;

  // The front end stalls only when the queue is full; it never waits on the
  // output side directly.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Front: parser state machine plus escape pass, one request per accepted cycle.
  // Requests that cause no result (spaces, discarded quotes) push nothing.
  clt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .line_end  (line_end),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue of result bundles.
  clt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: serializes each bundle onto the result channel.
  clt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (pop_data),
    .q_empty     (q_empty),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the command line tokenizer
// Drives byte requests and line ends, predicts every token byte and marker in
// a behavioral model of its own, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import clt_pkg::*;

  // ---------------------------------------------------------------- constants
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;     // long output hold-off
  localparam int LIMIT_CYCLES  = 400000;
  localparam int LINE_QUOTA    = 20;      // requests per pacing mix in random runs

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [55:0] META_SET = "<>();&|";

  // tokenizer modes and escape-pass quote tracking
  typedef enum logic [3:0] {
    PM_IDLE, PM_DQ, PM_SQ, PM_WORD, PM_DASH, PM_SHORT, PM_DASH2, PM_LONG,
    PM_EQ, PM_EQ_DQ, PM_EQ_SQ, PM_EQ_WORD
  } parse_mode_e;
  typedef enum logic [1:0] {Q_OUT, Q_DQ, Q_SQ} quote_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } tok_result_t;

  // ---------------------------------------------------------------- signals
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last_of_run;

  command_line_tokenizer_top i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_byte, .line_end,
    .out_valid, .out_stall, .out_byte, .out_kind, .last_of_run
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------- bench state
  tok_result_t expected_results[$];  // oldest first
  tok_result_t step_results[$];      // results of the request being predicted
  tok_result_t next_expected;
  logic [7:0]  line_q[$];            // command line under construction

  int error_count   = 0;
  int request_count = 0;
  int result_count  = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_count    = 0;
  int line_count    = 0;             // random lines sent, picks the setting
  bit hold_request  = 1'b0;

  // predictor copy of registers and state, reset values
  logic        escape_en   = 1'b1;
  logic        wrap_en     = 1'b0;
  parse_mode_e pmode       = PM_IDLE;
  logic        after_bs    = 1'b0;
  quote_mode_e quote_st    = Q_OUT;
  logic        esc_pending = 1'b0;
  logic        tok_open    = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_name(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic bit is_meta(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 7; k++)
      if (META_SET[8*k +: 8] == c) hit = 1'b1;
    return hit;
  endfunction

  // backslash r, n, t, a map to CR, LF, TAB, BEL
  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      "r":     return 8'h0D;
      "n":     return 8'h0A;
      "t":     return 8'h09;
      "a":     return 8'h07;
      default: return c;
    endcase
  endfunction

  // a request never yields more than MaxRes results
  function automatic void add_result(input logic [7:0] data, input logic [1:0] kind);
    tok_result_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    if (step_results.size() < MaxRes) step_results.push_back(r);
  endfunction

  // shell escape pass on one token byte
  function automatic void escape_token_byte(input logic [7:0] c);
    if (esc_pending) begin
      esc_pending = 1'b0;
      add_result(CH_BSLASH, KIND_BYTE);
      add_result(c, KIND_BYTE);
    end else if (c == CH_BSLASH) begin
      esc_pending = 1'b1;
    end else if (quote_st == Q_DQ) begin
      if (c == CH_DQUOTE) quote_st = Q_OUT;
      add_result(c, KIND_BYTE);
    end else if (quote_st == Q_SQ) begin
      if (c == CH_SQUOTE) begin
        quote_st = Q_OUT;
        if (wrap_en) add_result(CH_BSLASH, KIND_BYTE);
      end
      add_result(c, KIND_BYTE);
    end else if (is_meta(c)) begin
      add_result(CH_BSLASH, KIND_BYTE);
      add_result(c, KIND_BYTE);
    end else if (c == CH_DQUOTE) begin
      quote_st = Q_DQ;
      add_result(c, KIND_BYTE);
    end else if (c == CH_SQUOTE) begin
      quote_st = Q_SQ;
      add_result(CH_BSLASH, KIND_BYTE);
      add_result(c, KIND_BYTE);
    end else begin
      add_result(c, KIND_BYTE);
    end
  endfunction

  function automatic void push_token_byte(input logic [7:0] c);
    if (!tok_open) begin
      tok_open    = 1'b1;
      quote_st    = Q_OUT;
      esc_pending = 1'b0;
      if (wrap_en) add_result(CH_SQUOTE, KIND_BYTE);
    end
    if (escape_en) escape_token_byte(c);
    else add_result(c, KIND_BYTE);
  endfunction

  // an empty token emits nothing; a pending escape backslash is dropped
  function automatic void finish_token();
    if (tok_open) begin
      if (wrap_en) add_result(CH_SQUOTE, KIND_BYTE);
      add_result(8'h00, KIND_TOKEN_END);
    end
    tok_open    = 1'b0;
    quote_st    = Q_OUT;
    esc_pending = 1'b0;
  endfunction

  function automatic void close_to(input parse_mode_e m);
    pmode = m;
    finish_token();
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    if (after_bs) begin
      after_bs = 1'b0;
      push_token_byte(unescape(c));
    end else begin
      case (pmode)
        PM_DQ, PM_SQ: begin
          if (c == CH_BSLASH) after_bs = 1'b1;
          else if (c == ((pmode == PM_DQ) ? CH_DQUOTE : CH_SQUOTE)) close_to(PM_IDLE);
          else push_token_byte(c);
        end
        PM_WORD: begin
          // quotes inside a bare word are swallowed
          if (is_space(c)) close_to(PM_IDLE);
          else if (c != CH_DQUOTE && c != CH_SQUOTE) push_token_byte(c);
        end
        PM_DASH: begin
          if (c == CH_DASH) begin
            pmode = PM_DASH2;
            push_token_byte(c);
          end else if (is_name(c)) begin
            pmode = PM_SHORT;
            push_token_byte(c);
          end else begin
            close_to(PM_IDLE);
          end
        end
        PM_DASH2: begin
          if (is_name(c)) begin
            pmode = PM_LONG;
            push_token_byte(c);
          end else begin
            close_to(PM_IDLE);
          end
        end
        PM_SHORT, PM_LONG: begin
          if (is_name(c)) push_token_byte(c);
          else if (c == CH_EQUAL) close_to(PM_EQ);
          else close_to(PM_IDLE);
        end
        PM_EQ: begin
          if (is_space(c)) close_to(PM_IDLE);
          else if (c == CH_DQUOTE) pmode = PM_EQ_DQ;
          else if (c == CH_SQUOTE) pmode = PM_EQ_SQ;
          else begin
            pmode = PM_EQ_WORD;
            push_token_byte(c);
          end
        end
        PM_EQ_DQ, PM_EQ_SQ: begin
          if (c == ((pmode == PM_EQ_DQ) ? CH_DQUOTE : CH_SQUOTE)) close_to(PM_IDLE);
          else push_token_byte(c);
        end
        PM_EQ_WORD: begin
          if (is_space(c)) close_to(PM_IDLE);
          else push_token_byte(c);
        end
        default: begin
          pmode = PM_IDLE;
          if (is_space(c)) begin
          end else if (c == CH_DASH) begin
            pmode = PM_DASH;
            push_token_byte(c);
          end else if (c == CH_BSLASH) begin
            after_bs = 1'b1;
          end else if (c == CH_DQUOTE) begin
            pmode = PM_DQ;
          end else if (c == CH_SQUOTE) begin
            pmode = PM_SQ;
          end else if (c == CH_EQUAL) begin
            pmode = PM_EQ;
          end else begin
            pmode = PM_WORD;
            push_token_byte(c);
          end
        end
      endcase
    end
  endfunction

  // Works out every result of one accepted request and queues them.
  function automatic void tokenize_request(input logic [7:0] c, input logic eol);
    step_results.delete();
    if (eol) begin
      // a dangling backslash is dropped; the open token still closes
      after_bs = 1'b0;
      finish_token();
      pmode = PM_IDLE;
      add_result(8'h00, KIND_LINE_END);
    end else begin
      parse_char(c);
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------- driving
  // One request: optional idle gap first, then hold valid until accepted.
  task automatic send_req(input logic [7:0] c, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    line_end <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_request(c, eol);
    request_count++;
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle so
  // requests that made no result are through too.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ESCAPE) escape_en = val;
    else wrap_en = val;
  endtask

  // Sends the built line, then a line end with a random ignored byte.
  task automatic send_line();
    foreach (line_q[i]) send_req(line_q[i], 1'b0);
    send_req(8'($urandom_range(0, 255)), 1'b1);
    line_q.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  // ---------------------------------------------------------------- random content
  function automatic logic [7:0] pick_word_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'("a" + $urandom_range(0, 25));
      3:       return 8'("0" + $urandom_range(0, 9));
      4:       return META_SET[8*$urandom_range(0, 6) +: 8];
      5:       return CH_BSLASH;
      6:       return 8'($urandom_range(128, 255));
      7:       return 8'($urandom_range(0, 255));
      default: return 8'("A" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_name_byte();
    case ($urandom_range(0, 4))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("0" + $urandom_range(0, 9));
      2:       return ($urandom_range(0, 1) != 0) ? CH_DASH : CH_UNDER;
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_escaped();
    case ($urandom_range(0, 4))
      0:       return "r";
      1:       return "n";
      2:       return "t";
      3:       return "a";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_word();
    repeat ($urandom_range(1, 4)) line_q.push_back(pick_word_byte());
  endfunction

  // quoted span; body mixes plain bytes, spaces, the other quote and escapes
  function automatic void add_quoted(input logic [7:0] q, input bit closed);
    line_q.push_back(q);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 4))
        0: line_q.push_back(CH_SPACE);
        1: line_q.push_back((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
        2: begin
          line_q.push_back(CH_BSLASH);
          line_q.push_back(pick_escaped());
        end
        default: line_q.push_back(pick_word_byte());
      endcase
    end
    if (closed) line_q.push_back(q);
  endfunction

  // '=' followed by a bare, quoted or empty value
  function automatic void add_opt_value();
    line_q.push_back(CH_EQUAL);
    case ($urandom_range(0, 3))
      0: add_quoted(CH_DQUOTE, 1'b1);
      1: add_quoted(CH_SQUOTE, 1'b1);
      2: ;
      default: add_word();
    endcase
  endfunction

  // Mostly well formed words, quotes and options; some noise and broken forms.
  function automatic void build_random_line();
    int n_tok;
    n_tok = $urandom_range(1, 4);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 11))
        2: add_quoted(CH_DQUOTE, 1'b1);
        3: add_quoted(CH_SQUOTE, 1'b1);
        4: begin
          line_q.push_back(CH_DASH);
          line_q.push_back(pick_name_byte());
          if ($urandom_range(0, 1) != 0) add_opt_value();
        end
        5: begin
          line_q.push_back(CH_DASH);
          line_q.push_back(CH_DASH);
          repeat ($urandom_range(1, 3)) line_q.push_back(pick_name_byte());
          if ($urandom_range(0, 3) != 0) add_opt_value();
        end
        6: begin
          line_q.push_back(CH_BSLASH);
          line_q.push_back(pick_escaped());
          if ($urandom_range(0, 1) != 0) add_word();
        end
        7: add_opt_value();
        8: repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
        9: begin
          // broken forms: open quote, dash into junk, bare double dash
          case ($urandom_range(0, 2))
            0: add_quoted(($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
            1: begin
              line_q.push_back(CH_DASH);
              line_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
              line_q.push_back(CH_DASH);
              line_q.push_back(CH_DASH);
            end
          endcase
        end
        default: add_word();
      endcase
      if (t < n_tok - 1 || $urandom_range(0, 3) == 0)
        line_q.push_back(($urandom_range(0, 3) == 0) ? 8'(9 + $urandom_range(0, 4)) : CH_SPACE);
    end
    // now and then a backslash right before the line end
    if ($urandom_range(0, 7) == 0) line_q.push_back(CH_BSLASH);
  endfunction

  // ---------------------------------------------------------------- tests
  // Reset settings (escape on, wrap off): option with value, zero and 0xFF
  // bytes, empty quotes, swallowed quote in a word, a metacharacter inside
  // quotes, a token of a lone backslash and a backslash at line end.
  task automatic test_directed_parse();
    add_text("-x=");
    line_q.push_back(8'h00);
    add_text(" \"\"ab\"c '");
    line_q.push_back(8'hFF);
    add_text(";' \"\\\\\" z\\");
    send_line();
  endtask

  // Wrap on: single quotes in a token toggle quoting inside the escape pass;
  // the four named escapes and one plain escaped letter.
  task automatic test_wrap_escapes();
    write_reg(REG_WRAP, 1'b1);
    add_text("\"x'y'\" \\r\\n\\t\\a\\q");
    send_line();
  endtask

  // Register change part way through a token applies from the next byte.
  task automatic test_config_mid_token();
    send_req("a", 1'b0);
    write_reg(REG_ESCAPE, 1'b0);
    write_reg(REG_WRAP, 1'b0);
    send_req("<", 1'b0);
    send_req(CH_SQUOTE, 1'b0);
    send_req(8'h00, 1'b1);
  endtask

  // Random lines with the given pacing; each line takes the next of the four
  // escape/wrap settings in turn.
  task automatic test_random_lines(input int send_pct, input int recv_pct);
    int start_count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count   = request_count;
    while (request_count - start_count < LINE_QUOTA) begin
      write_reg(REG_ESCAPE, line_count[0]);
      write_reg(REG_WRAP, line_count[1]);
      line_count++;
      build_random_line();
      send_line();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the result queue fills and the block stalls its input.
  task automatic test_output_hold();
    send_idle_pct = 0;
    hold_request  = 1'b1;
    build_random_line();
    add_text("--fill='<&>' abc");
    send_line();
    wait_idle();
    hold_request = 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver
  // Random stall, or a counted hold-off while one is asked for.
  always @(posedge clk) begin
    if (hold_request && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_stall  <= 1'b1;
    end else begin
      if (!hold_request) hold_count <= 0;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- checker
  // Values read here are those before the edge, as the block saw them.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result with none expected: out_byte %02h out_kind %0d last_of_run %0b",
               out_byte, out_kind, last_of_run);
        error_count++;
      end else begin
        next_expected = expected_results.pop_front();
        if (out_byte !== next_expected.data) begin
          $error("out_byte expected %02h actual %02h", next_expected.data, out_byte);
          error_count++;
        end
        if (out_kind !== next_expected.kind) begin
          $error("out_kind expected %0d actual %0d", next_expected.kind, out_kind);
          error_count++;
        end
        if (last_of_run !== next_expected.last) begin
          $error("last_of_run expected %0b actual %0b", next_expected.last, last_of_run);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // sender gaps light, receiver stalls heavy
    send_idle_pct = 31;
    recv_idle_pct = 86;
    test_directed_parse();
    test_wrap_escapes();
    test_config_mid_token();
    test_random_lines(31, 86);
    // then the other way round, then no gaps at all
    test_random_lines(86, 31);
    test_random_lines(0, 0);
    test_output_hold();
    wait_idle();

    $display("Sent %0d requests and checked %0d results across three pacing mixes,",
             request_count, result_count);
    $display("every escape/wrap setting and one long output hold-off.");
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
